### rtl/core/dsp_pkg.sv
package dsp_pkg;

   // Date format codes held in the format register.
   localparam logic [1:0] FMT_MDY = 2'd0;
   localparam logic [1:0] FMT_DMY = 2'd1;
   localparam logic [1:0] FMT_YMD = 2'd2;
   localparam logic [1:0] FMT_ISO = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_DATE_FORMAT = 2'd0;
   localparam logic [1:0] REG_SHORT_EN    = 2'd1;
   localparam logic [1:0] REG_REF_YEAR    = 2'd2;
   localparam logic [1:0] REG_REF_MONTH   = 2'd3;

   // Character codes.
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Accepted year range.
   localparam logic [16:0] YEAR_MIN = 17'd1902;
   localparam logic [16:0] YEAR_MAX = 17'd2037;

   // Field accumulator ceiling.
   localparam logic [19:0] FIELD_MAX = 20'd65535;

   // Reciprocal of 100 for a 14-bit dividend: q = (x * 5243) >> 19.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   // Reset values of the reference registers.
   localparam logic [13:0] REF_YEAR_RESET  = 14'd2000;
   localparam logic [7:0]  CENT_Q_RESET    = 8'd20;
   localparam logic [3:0]  REF_MONTH_RESET = 4'd1;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [1:0]  date_format;
      logic        short_en;
      logic [13:0] ref_year;
      logic [7:0]  cent_q;      // ref_year / 100
      logic [3:0]  ref_month;
   } cfg_type;

   // Date fields captured at the terminator, already mapped to year, month and day.
   typedef struct packed {
      logic        ok;          // string well formed, last field non-zero
      logic        n_lt2;       // fewer than two separators
      logic        n_lt1;       // no separator at all
      logic [15:0] year;
      logic [15:0] month;
      logic [15:0] day;
   } term_type;

   // Days in a month, without the leap day; codes outside 1 to 12 give zero.
   function automatic logic [4:0] month_days(input logic [3:0] m);
      logic [4:0] d;
      case (m)
         4'd2: d = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         default: d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

### rtl/core/dsp_accum.sv
module dsp_accum (
   input  logic               clock,
   input  logic               reset,
   input  dsp_pkg::cfg_type   cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_end_of_string,
   output logic               term_valid,
   input  logic               term_ready,
   output dsp_pkg::term_type  term
);

   // Input register.
   logic        a_valid_ff, a_valid_in;
   logic [7:0]  a_char_ff;
   logic        a_eos_ff;

   // String state.
   logic [15:0] field_ff [3];
   logic [15:0] field_in [3];
   logic [1:0]  sep_cnt_ff, sep_cnt_in;
   logic        bad_ff, bad_in;

   // Terminal capture register.
   logic              term_valid_ff;
   dsp_pkg::term_type term_ff, term_in;

   logic        b_ready;
   logic        a_fire;
   logic        a_ready;
   logic        load;
   logic [7:0]  sep_char;
   logic        is_digit;
   logic [3:0]  digit;
   logic [15:0] cur;
   logic [19:0] cur_ext;
   logic [19:0] acc;
   logic [15:0] acc_sat;
   logic [1:0]  n_c;
   logic [15:0] last_field;

   // Handshake between the input register and the capture register.
   assign b_ready   = !term_valid_ff || term_ready;
   assign a_fire    = a_valid_ff && (!a_eos_ff || b_ready);
   assign a_ready   = !a_valid_ff || a_fire;
   assign req_stall = !a_ready;
   assign load      = req_valid && a_ready;
   assign a_valid_in = load ? 1'b1 : (a_fire ? 1'b0 : a_valid_ff);

   // Separator follows the current format.
   assign sep_char = (cfg.date_format == dsp_pkg::FMT_ISO) ? dsp_pkg::CHAR_DASH
                                                            : dsp_pkg::CHAR_SLASH;
   assign is_digit = (a_char_ff >= dsp_pkg::CHAR_ZERO) && (a_char_ff <= dsp_pkg::CHAR_NINE);
   // The low nibble of a digit character is its value.
   assign digit    = a_char_ff[3:0];

   // Field selected by the separator count.
   always_comb begin
      case (sep_cnt_ff)
         2'd0: cur = field_ff[0];
         2'd1: cur = field_ff[1];
         default: cur = field_ff[2];
      endcase
   end

   // Multiply by ten and add the digit, saturating at the field ceiling.
   assign cur_ext = {4'b0, cur};
   assign acc     = (cur_ext << 3) + (cur_ext << 1) + {16'b0, digit};
   assign acc_sat = (acc > dsp_pkg::FIELD_MAX) ? 16'hFFFF : acc[15:0];

   // Next string state for one character beat, or a clear at the terminator.
   always_comb begin
      field_in   = field_ff;
      sep_cnt_in = sep_cnt_ff;
      bad_in     = bad_ff;
      if (a_fire) begin
         if (a_eos_ff) begin
            field_in[0] = '0;
            field_in[1] = '0;
            field_in[2] = '0;
            sep_cnt_in  = '0;
            bad_in      = 1'b0;
         end else if (!bad_ff && sep_cnt_ff <= 2'd2) begin
            if (a_char_ff == sep_char) begin
               if (sep_cnt_ff >= 2'd2) begin
                  bad_in = 1'b1;
               end else begin
                  sep_cnt_in = sep_cnt_ff + 2'd1;
               end
            end else if (is_digit) begin
               case (sep_cnt_ff)
                  2'd0: field_in[0] = acc_sat;
                  2'd1: field_in[1] = acc_sat;
                  2'd2: field_in[2] = acc_sat;
                  default: ;
               endcase
            end else begin
               bad_in = 1'b1;
            end
         end
      end
   end

   // Map the fields to year, month and day as the format orders them.
   assign n_c = (sep_cnt_ff > 2'd2) ? 2'd2 : sep_cnt_ff;

   always_comb begin
      case (n_c)
         2'd0: last_field = field_ff[0];
         2'd1: last_field = field_ff[1];
         default: last_field = field_ff[2];
      endcase
   end

   always_comb begin
      term_in       = term_ff;
      term_in.n_lt2 = (n_c < 2'd2);
      term_in.n_lt1 = (n_c < 2'd1);
      term_in.ok    = !bad_ff && !((!cfg.short_en && n_c < 2'd2) || last_field == 16'd0);
      case (cfg.date_format)
         dsp_pkg::FMT_MDY: begin
            term_in.month = (n_c >= 2'd1) ? field_ff[0] : 16'd0;
            term_in.day   = (n_c >= 2'd1) ? field_ff[1] : field_ff[0];
            term_in.year  = field_ff[2];
         end
         dsp_pkg::FMT_DMY: begin
            term_in.day   = field_ff[0];
            term_in.month = field_ff[1];
            term_in.year  = field_ff[2];
         end
         default: begin
            term_in.day = last_field;
            case (n_c)
               2'd0: begin
                  term_in.year  = 16'd0;
                  term_in.month = 16'd0;
               end
               2'd1: begin
                  term_in.year  = 16'd0;
                  term_in.month = field_ff[0];
               end
               default: begin
                  term_in.year  = field_ff[0];
                  term_in.month = field_ff[1];
               end
            endcase
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         field_ff[0]   <= '0;
         field_ff[1]   <= '0;
         field_ff[2]   <= '0;
         sep_cnt_ff    <= '0;
         bad_ff        <= 1'b0;
         term_valid_ff <= 1'b0;
      end else begin
         a_valid_ff  <= a_valid_in;
         field_ff    <= field_in;
         sep_cnt_ff  <= sep_cnt_in;
         bad_ff      <= bad_in;
         if (b_ready) begin
            term_valid_ff <= a_fire && a_eos_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         a_char_ff <= req_char_code;
         a_eos_ff  <= req_end_of_string;
      end
      if (b_ready && a_fire && a_eos_ff) begin
         term_ff <= term_in;
      end
   end

   assign term_valid = term_valid_ff;
   assign term       = term_ff;

endmodule

### rtl/core/dsp_check.sv
module dsp_check (
   input  logic               clock,
   input  logic               reset,
   input  dsp_pkg::cfg_type   cfg,
   input  logic               term_valid,
   output logic               term_ready,
   input  dsp_pkg::term_type  term,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_valid_res,
   output logic [10:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day
);

   logic        out_valid_ff;
   logic        res_ok_ff, res_ok_in;
   logic [10:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;

   logic        c_ready;
   logic [13:0] q_ext;
   logic [13:0] century;
   logic [16:0] y_sum;
   logic [16:0] yf;
   logic [15:0] mf;
   logic        in_range;
   logic        leap;
   logic [4:0]  limit;
   logic        good;

   assign c_ready    = !out_valid_ff || !rsp_stall;
   assign term_ready = c_ready;

   // Century of the reference year: q * 100 as shifts and adds.
   assign q_ext   = {6'b0, cfg.cent_q};
   assign century = (q_ext << 6) + (q_ext << 5) + (q_ext << 2);
   assign y_sum   = {1'b0, term.year} + {3'b0, century};

   // Short forms add the reference century to a two-digit year, or fill the year and month from the reference date.
   always_comb begin
      yf = {1'b0, term.year};
      mf = term.month;
      if (cfg.short_en) begin
         if (term.year != 16'd0 && term.year < 16'd100) begin
            yf = y_sum;
         end else if (term.n_lt2) begin
            yf = {3'b0, cfg.ref_year};
            if (term.n_lt1) begin
               mf = {12'b0, cfg.ref_month};
            end
         end
      end
   end

   // Range checks. Within 1902 to 2037 every year divisible by four is a leap year.
   assign in_range = term.ok && (yf >= dsp_pkg::YEAR_MIN) && (yf <= dsp_pkg::YEAR_MAX) &&
                     (mf >= 16'd1) && (mf <= 16'd12) && (term.day >= 16'd1);
   assign leap     = (yf[1:0] == 2'd0);
   assign limit    = dsp_pkg::month_days(mf[3:0]) + {4'b0, (mf == 16'd2) && leap};
   assign good     = in_range && (term.day <= {11'b0, limit});

   assign res_ok_in = good;
   assign year_in   = good ? yf[10:0] : 11'd0;
   assign month_in  = good ? mf[3:0]  : 4'd0;
   assign day_in    = good ? term.day[4:0] : 5'd0;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (c_ready) begin
         out_valid_ff <= term_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && term_valid) begin
         res_ok_ff <= res_ok_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_valid_res = res_ok_ff;
   assign rsp_year      = year_ff;
   assign rsp_month     = month_ff;
   assign rsp_day       = day_ff;

endmodule

### rtl/core/date_string_parser.sv
// Date string parser.
// The request channel carries one beat per character of a date string:
// req_char_code with req_end_of_string low, and a final terminator beat with
// req_end_of_string high. Digits build up to three fields split by '/' (or by
// '-' in ISO format). The terminator yields one response beat with
// rsp_valid_res and the parsed year, month and day (all zero when invalid).
// Character beats yield no response.
// Throughput is one beat per cycle while req_stall is low; the field
// accumulator multiplies by ten and adds a digit combinationally between the
// input register and the state registers. A terminator passes through the
// input register and then the capture register, and then the result register
// drives rsp_valid.
// While rsp_stall holds a waiting response, character beats keep flowing and
// one more terminator is held in the capture register; req_stall rises only
// once a further terminator reaches the input register.
// Reset clears the string state, the pipeline and the registers to format 0,
// short forms off, reference year 2000 and reference month 1. The user must
// write csr_ port registers only while the block is idle; the block does not enforce it.
module date_string_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [10:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [1:0]  date_format_ff;
   logic        short_en_ff;
   logic [13:0] ref_year_ff;
   logic [7:0]  cent_q_ff;
   logic [3:0]  ref_month_ff;

   logic              wr_en;
   logic [1:0]        reg_idx;
   logic [26:0]       recip_prod;
   dsp_pkg::cfg_type  cfg;
   logic              term_valid;
   logic              term_ready;
   dsp_pkg::term_type term;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign recip_prod = {13'b0, csr_pwdata[13:0]} * {14'b0, dsp_pkg::RECIP_100};

   always_ff @(posedge clock) begin
      if (reset) begin
         date_format_ff <= dsp_pkg::FMT_MDY;
         short_en_ff    <= 1'b0;
         ref_year_ff    <= dsp_pkg::REF_YEAR_RESET;
         cent_q_ff      <= dsp_pkg::CENT_Q_RESET;
         ref_month_ff   <= dsp_pkg::REF_MONTH_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            dsp_pkg::REG_DATE_FORMAT: date_format_ff <= csr_pwdata[1:0];
            dsp_pkg::REG_SHORT_EN:    short_en_ff    <= csr_pwdata[0];
            dsp_pkg::REG_REF_YEAR: begin
               ref_year_ff <= csr_pwdata[13:0];
               cent_q_ff   <= recip_prod[dsp_pkg::RECIP_SHIFT+7:dsp_pkg::RECIP_SHIFT];
            end
            dsp_pkg::REG_REF_MONTH:   ref_month_ff   <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (reg_idx)
         dsp_pkg::REG_DATE_FORMAT: csr_prdata = {30'b0, date_format_ff};
         dsp_pkg::REG_SHORT_EN:    csr_prdata = {31'b0, short_en_ff};
         dsp_pkg::REG_REF_YEAR:    csr_prdata = {18'b0, ref_year_ff};
         dsp_pkg::REG_REF_MONTH:   csr_prdata = {28'b0, ref_month_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg.date_format = date_format_ff;
   assign cfg.short_en    = short_en_ff;
   assign cfg.ref_year    = ref_year_ff;
   assign cfg.cent_q      = cent_q_ff;
   assign cfg.ref_month   = ref_month_ff;

   // Character accumulation and terminal capture.
   dsp_accum u_accum (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .term_valid        (term_valid),
      .term_ready        (term_ready),
      .term              (term)
   );

   // Date check and result register.
   dsp_check u_check (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .term_valid    (term_valid),
      .term_ready    (term_ready),
      .term          (term),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res),
      .rsp_year      (rsp_year),
      .rsp_month     (rsp_month),
      .rsp_day       (rsp_day)
   );

`ifndef ASSERT_OFF
   // An invalid date carries zero fields.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_year == 11'd0 && rsp_month == 4'd0 &&
                                         rsp_day == 5'd0))
      else $error("invalid response with non-zero fields");

   // A valid date lies within the accepted range.
   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_year >= 11'd1902 && rsp_year <= 11'd2037 &&
                                        rsp_month >= 4'd1 && rsp_month <= 4'd12 &&
                                        rsp_day >= 5'd1))
      else $error("valid response out of range");

   // With the result register empty the input side never stalls.
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty result register");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");
`endif

endmodule
